// ----- src/obm_pkg.sv -----
// Shared types and constants for the 1-wire bus master.
// No dependencies; imported by every module of the block.
package obm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RS_PRE   = 4'd1,
        PH_RS_LOW1  = 4'd2,
        PH_RS_LOW2  = 4'd3,
        PH_RS_REL   = 4'd4,
        PH_RS_PWAIT = 4'd5,
        PH_RS_SHORT = 4'd6,
        PH_RS_LONG  = 4'd7,
        PH_RS_FINAL = 4'd8,
        PH_W_LOW    = 4'd9,
        PH_W_SLOT   = 4'd10,
        PH_R_LOW    = 4'd11,
        PH_R_WAIT   = 4'd12,
        PH_R_REC    = 4'd13,
        PH_GAP      = 4'd14
    } t_phase;

    typedef logic [2:0] t_req;
    localparam t_req REQ_TICK  = 3'd0;
    localparam t_req REQ_RESET = 3'd1;
    localparam t_req REQ_WBYTE = 3'd2;
    localparam t_req REQ_RBYTE = 3'd3;
    localparam t_req REQ_WBIT  = 3'd4;
    localparam t_req REQ_RBIT  = 3'd5;

    typedef logic [3:0] t_status;
    localparam t_status ST_OK        = 4'd0;
    localparam t_status ST_PRESENT   = 4'd1;
    localparam t_status ST_NO_DEV    = 4'd2;
    localparam t_status ST_BUS_LOW   = 4'd3;
    localparam t_status ST_NO_LOW    = 4'd4;
    localparam t_status ST_STUCK     = 4'd5;
    localparam t_status ST_SHORT     = 4'd6;
    localparam t_status ST_LONG      = 4'd7;
    localparam t_status ST_REJECTED  = 4'd8;

    typedef enum logic [2:0] {
        REG_WR1_LOW  = 3'd0,
        REG_WR_SLOT  = 3'd1,
        REG_RD_LOW   = 3'd2,
        REG_RD_SAMP  = 3'd3,
        REG_RD_REC   = 3'd4,
        REG_RST_HALF = 3'd5,
        REG_PR_WAIT  = 3'd6,
        REG_PR_HOLD  = 3'd7
    } t_reg_idx;

    localparam logic [8:0] RELEASE_SETTLE = 9'd5;
    localparam logic [8:0] FIXED_CHECK    = 9'd10;
    localparam logic [2:0] LAST_BIT       = 3'd7;

    typedef struct packed {
        logic [3:0] write_one_low_ticks;
        logic [6:0] write_slot_ticks;
        logic [3:0] read_low_ticks;
        logic [3:0] read_sample_ticks;
        logic [6:0] read_recovery_ticks;
        logic [8:0] reset_half_ticks;
        logic [6:0] presence_wait_ticks;
        logic [8:0] presence_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic       busy_res;
        logic [7:0] rx_byte;
        t_status    status;
        logic       done_res;
        logic       bus_drive_low;
    } t_result;

endpackage

// ----- src/obm_cfg_regs.sv -----
// APB-style register file holding the slot timing registers.
// Depends on obm_pkg.
module obm_cfg_regs
    import obm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_one_low_ticks <= 4'd4;
            r_cfg.write_slot_ticks    <= 7'd54;
            r_cfg.read_low_ticks      <= 4'd1;
            r_cfg.read_sample_ticks   <= 4'd6;
            r_cfg.read_recovery_ticks <= 7'd60;
            r_cfg.reset_half_ticks    <= 9'd250;
            r_cfg.presence_wait_ticks <= 7'd60;
            r_cfg.presence_hold_ticks <= 9'd240;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WR1_LOW:  r_cfg.write_one_low_ticks <= pwdata[3:0];
                REG_WR_SLOT:  r_cfg.write_slot_ticks    <= pwdata[6:0];
                REG_RD_LOW:   r_cfg.read_low_ticks      <= pwdata[3:0];
                REG_RD_SAMP:  r_cfg.read_sample_ticks   <= pwdata[3:0];
                REG_RD_REC:   r_cfg.read_recovery_ticks <= pwdata[6:0];
                REG_RST_HALF: r_cfg.reset_half_ticks    <= pwdata[8:0];
                REG_PR_WAIT:  r_cfg.presence_wait_ticks <= pwdata[6:0];
                REG_PR_HOLD:  r_cfg.presence_hold_ticks <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WR1_LOW:  prdata = 32'(r_cfg.write_one_low_ticks);
            REG_WR_SLOT:  prdata = 32'(r_cfg.write_slot_ticks);
            REG_RD_LOW:   prdata = 32'(r_cfg.read_low_ticks);
            REG_RD_SAMP:  prdata = 32'(r_cfg.read_sample_ticks);
            REG_RD_REC:   prdata = 32'(r_cfg.read_recovery_ticks);
            REG_RST_HALF: prdata = 32'(r_cfg.reset_half_ticks);
            REG_PR_WAIT:  prdata = 32'(r_cfg.presence_wait_ticks);
            REG_PR_HOLD:  prdata = 32'(r_cfg.presence_hold_ticks);
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/obm_core.sv -----
// Slot sequencer: phase/tick state and the per-tick next-state logic.
// Depends on obm_pkg; timing comes from obm_cfg_regs.
module obm_core
    import obm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_req       i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_bus_sense,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    t_req       r_op, n_op;
    logic [8:0] r_tick, n_tick;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_drive, n_drive;

    logic       w_done;
    t_status    w_status;
    logic [7:0] w_rx;
    logic       w_is_cmd;
    logic       w_cur_wr;
    logic       w_new_wr;
    logic       w_byte_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= REQ_TICK;
            r_tick  <= 9'd0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_drive <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_drive <= n_drive;
        end
    end

    assign w_is_cmd  = (i_req_type >= REQ_RESET) && (i_req_type <= REQ_RBIT);
    assign w_cur_wr  = (r_op == REQ_WBYTE) || (r_op == REQ_WBIT);
    assign w_new_wr  = (i_req_type == REQ_WBYTE) || (i_req_type == REQ_WBIT);
    assign w_byte_op = (r_op == REQ_WBYTE) || (r_op == REQ_RBYTE);

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_drive  = r_drive;
        w_done   = 1'b0;
        w_status = ST_OK;
        w_rx     = 8'd0;

        if (r_phase == PH_IDLE) begin
            if (w_is_cmd) begin
                n_op  = i_req_type;
                n_bit = 3'd0;
                if (i_req_type == REQ_RESET) begin
                    n_shift = 8'd0;
                    n_drive = 1'b0;
                    n_phase = PH_RS_PRE;
                    n_tick  = RELEASE_SETTLE;
                end else begin
                    n_shift = w_new_wr ? i_tx_byte : 8'd0;
                    n_drive = 1'b1;
                    if (w_new_wr) begin
                        n_phase = PH_W_LOW;
                        n_tick  = 9'(i_cfg.write_one_low_ticks);
                    end else begin
                        n_phase = PH_R_LOW;
                        n_tick  = 9'(i_cfg.read_low_ticks);
                    end
                end
            end
        end else if (r_tick > 9'd1) begin
            n_tick = r_tick - 9'd1;
        end else begin
            unique case (r_phase) inside
                PH_RS_PRE: begin
                    if (!i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_BUS_LOW;
                    end else begin
                        n_drive = 1'b1;
                        n_phase = PH_RS_LOW1;
                        n_tick  = i_cfg.reset_half_ticks;
                    end
                end
                PH_RS_LOW1: begin
                    if (i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_NO_LOW;
                    end else begin
                        n_phase = PH_RS_LOW2;
                        n_tick  = i_cfg.reset_half_ticks;
                    end
                end
                PH_RS_LOW2: begin
                    n_drive = 1'b0;
                    n_phase = PH_RS_REL;
                    n_tick  = FIXED_CHECK;
                end
                PH_RS_REL: begin
                    if (!i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_STUCK;
                    end else begin
                        n_phase = PH_RS_PWAIT;
                        n_tick  = 9'(i_cfg.presence_wait_ticks);
                    end
                end
                PH_RS_PWAIT: begin
                    if (i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_NO_DEV;
                    end else begin
                        n_phase = PH_RS_SHORT;
                        n_tick  = FIXED_CHECK;
                    end
                end
                PH_RS_SHORT: begin
                    if (i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_SHORT;
                    end else begin
                        n_phase = PH_RS_LONG;
                        n_tick  = i_cfg.presence_hold_ticks;
                    end
                end
                PH_RS_LONG: begin
                    if (!i_bus_sense) begin
                        w_done = 1'b1; w_status = ST_LONG;
                    end else begin
                        n_phase = PH_RS_FINAL;
                        n_tick  = i_cfg.presence_hold_ticks;
                    end
                end
                PH_RS_FINAL: begin
                    w_done = 1'b1; w_status = ST_PRESENT;
                end
                PH_W_LOW: begin
                    if (r_shift[0]) begin
                        n_drive = 1'b0;
                    end
                    n_phase = PH_W_SLOT;
                    n_tick  = 9'(i_cfg.write_slot_ticks);
                end
                PH_W_SLOT, PH_R_REC: begin
                    if (r_phase == PH_W_SLOT) begin
                        n_shift = {1'b0, r_shift[7:1]};
                    end
                    n_drive = 1'b0;
                    if (w_byte_op && (r_bit < LAST_BIT)) begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_GAP;
                        n_tick  = 9'd1;
                    end else begin
                        w_done = 1'b1;
                        if (r_op == REQ_RBYTE) begin
                            w_rx = r_shift;
                        end else if (r_op == REQ_RBIT) begin
                            w_rx = {7'd0, r_shift[7]};
                        end
                    end
                end
                PH_R_LOW: begin
                    n_drive = 1'b0;
                    n_phase = PH_R_WAIT;
                    n_tick  = 9'(i_cfg.read_sample_ticks);
                end
                PH_R_WAIT: begin
                    n_shift = {i_bus_sense, r_shift[7:1]};
                    n_phase = PH_R_REC;
                    n_tick  = 9'(i_cfg.read_recovery_ticks);
                end
                PH_GAP: begin
                    n_drive = 1'b1;
                    if (w_cur_wr) begin
                        n_phase = PH_W_LOW;
                        n_tick  = 9'(i_cfg.write_one_low_ticks);
                    end else begin
                        n_phase = PH_R_LOW;
                        n_tick  = 9'(i_cfg.read_low_ticks);
                    end
                end
                default: begin
                    n_drive = 1'b0;
                    n_phase = PH_IDLE;
                    n_tick  = 9'd0;
                end
            endcase
            if (w_done) begin
                n_drive = 1'b0;
                n_phase = PH_IDLE;
                n_tick  = 9'd0;
            end
        end

        if (r_phase != PH_IDLE && !w_done && w_is_cmd) begin
            w_status = ST_REJECTED;
        end

        o_result.bus_drive_low = n_drive;
        o_result.done_res      = w_done;
        o_result.status        = w_status;
        o_result.rx_byte       = w_rx;
        o_result.busy_res      = (n_phase != PH_IDLE);
    end

`ifndef SYNTHESIS
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> !r_drive)
        else $error("line driven low while idle");
    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick == 9'd0)
        else $error("tick count left over in idle");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_done |=> r_phase == PH_IDLE)
        else $error("command done but sequencer still busy");
    a_reject_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status == ST_REJECTED |-> r_phase != PH_IDLE && !w_done)
        else $error("reject flagged while idle");
`endif

endmodule

// ----- src/onewire_bus_master_unit.sv -----
// 1-wire bus master, one microsecond tick per stream request.
// Channels: s_axis carries each tick (command kind in tuser, byte and
// sampled line level in tdata); m_axis returns one result per tick.
// Configuration: eight slot timing registers on an APB-style port, 4-byte
// stride; the user must write them only while the bus is idle, and the
// block itself does not enforce it. Each tick's result goes out registered.
// Throughput: one tick per cycle while m_axis is not stalled; the sequencer
// state and the output register both advance on each accepted request.
// The output register frees itself when m_axis is taken, so s_axis_tready
// stays high while the result register is empty or being drained. When the
// receiver stalls, the held result waits and s_axis_tready drops; no tick
// is lost and the sequencer does not advance.
// Reset: synchronous, active low; the line is released, the sequencer goes
// idle, the output holds no result and the timing registers take their
// default values.
module onewire_bus_master_unit
    import obm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] bus_sense, zero pad
    input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [0] bus_drive_low, [1] done_res,
                                       // [5:2] status, [13:6] rx_byte,
                                       // [14] busy_res, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_valid;
    logic    w_accept;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    obm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    obm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_accept),
        .i_req_type  (s_axis_tuser),
        .i_tx_byte   (s_axis_tdata[7:0]),
        .i_bus_sense (s_axis_tdata[8]),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, r_result};

endmodule

// ----- tb/onewire_bus_master_unit_tb.sv -----
// Testbench for onewire_bus_master_unit: streams tick requests with a simulated
// line level, predicts every result in a local sequencer model and checks it.
// Depends on obm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module onewire_bus_master_unit_tb;
    import obm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam t_req REQ_SPARE6 = 3'd6;
    localparam t_req REQ_SPARE7 = 3'd7;

    localparam t_cfg TIMING_DEFAULT = '{4'd4, 7'd54, 4'd1, 4'd6, 7'd60, 9'd250, 7'd60, 9'd240};
    localparam t_cfg TIMING_FAST = '{4'd1, 7'd45, 4'd1, 4'd1, 7'd45, 9'd240, 7'd15, 9'd60};
    localparam t_cfg TIMING_SLOW = '{4'd15, 7'd120, 4'd15, 4'd15, 7'd120, 9'd500, 7'd100,
                                     9'd480};
    localparam t_cfg TIMING_SHORT = '{4'd2, 7'd2, 4'd1, 4'd2, 7'd2, 9'd2, 7'd2, 9'd2};
    localparam t_cfg TIMING_ZERO = '0;
    localparam t_cfg TIMING_ONES = '1;

    typedef struct packed {
        t_phase     ph;
        t_req       op;
        logic [8:0] cnt;
        logic [3:0] bidx;
        logic [7:0] sh;
        logic       drv;
    } t_bus_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] tx_byte, [8] bus_sense, zero pad
    logic [2:0]  s_axis_tuser = '0;   // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] drive, [1] done, [5:2] status,
                                      // [13:6] rx_byte, [14] busy, zero pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_cfg       timing = TIMING_DEFAULT;
    t_bus_state master = '0;
    t_result    tick_results[$];
    t_status    reset_outcome = ST_PRESENT;
    int         fail_cnt = 0;
    int         src_gap_pct = 0;
    int         sink_stall_pct = 0;
    int         sink_hold = 0;
    int         cycle_cnt = 0;

    onewire_bus_master_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sequencer model

    function automatic t_bus_state open_slot(input t_bus_state s);
        s.drv = 1'b1;
        if (s.op == REQ_WBYTE || s.op == REQ_WBIT) begin
            s.ph  = PH_W_LOW;
            s.cnt = 9'(timing.write_one_low_ticks);
        end else begin
            s.ph  = PH_R_LOW;
            s.cnt = 9'(timing.read_low_ticks);
        end
        return s;
    endfunction

    function automatic t_result master_tick(input t_bus_state now, input t_req req,
                                            input logic [7:0] tx, input logic level,
                                            output t_bus_state s);
        t_result r;
        logic    is_cmd;
        logic    fin;
        logic    slot_end;
        t_status fin_st;
        s        = now;
        r        = '0;
        fin      = 1'b0;
        slot_end = 1'b0;
        fin_st   = ST_OK;
        is_cmd   = (req >= REQ_RESET && req <= REQ_RBIT);
        if (s.ph == PH_IDLE) begin
            if (is_cmd) begin
                s.op   = req;
                s.bidx = '0;
                if (req == REQ_RESET) begin
                    s.sh  = '0;
                    s.drv = 1'b0;
                    s.ph  = PH_RS_PRE;
                    s.cnt = RELEASE_SETTLE;
                end else begin
                    s.sh = (req == REQ_WBYTE || req == REQ_WBIT) ? tx : 8'd0;
                    s    = open_slot(s);
                end
            end
        end else begin
            if (s.cnt > 9'd1) begin
                s.cnt = s.cnt - 9'd1;
            end else begin
                case (s.ph)
                    PH_RS_PRE: begin
                        if (!level) begin
                            fin = 1'b1; fin_st = ST_BUS_LOW;
                        end else begin
                            s.drv = 1'b1; s.ph = PH_RS_LOW1; s.cnt = timing.reset_half_ticks;
                        end
                    end
                    PH_RS_LOW1: begin
                        if (level) begin
                            fin = 1'b1; fin_st = ST_NO_LOW;
                        end else begin
                            s.ph = PH_RS_LOW2; s.cnt = timing.reset_half_ticks;
                        end
                    end
                    PH_RS_LOW2: begin
                        s.drv = 1'b0; s.ph = PH_RS_REL; s.cnt = FIXED_CHECK;
                    end
                    PH_RS_REL: begin
                        if (!level) begin
                            fin = 1'b1; fin_st = ST_STUCK;
                        end else begin
                            s.ph = PH_RS_PWAIT; s.cnt = 9'(timing.presence_wait_ticks);
                        end
                    end
                    PH_RS_PWAIT: begin
                        if (level) begin
                            fin = 1'b1; fin_st = ST_NO_DEV;
                        end else begin
                            s.ph = PH_RS_SHORT; s.cnt = FIXED_CHECK;
                        end
                    end
                    PH_RS_SHORT: begin
                        if (level) begin
                            fin = 1'b1; fin_st = ST_SHORT;
                        end else begin
                            s.ph = PH_RS_LONG; s.cnt = timing.presence_hold_ticks;
                        end
                    end
                    PH_RS_LONG: begin
                        if (!level) begin
                            fin = 1'b1; fin_st = ST_LONG;
                        end else begin
                            s.ph = PH_RS_FINAL; s.cnt = timing.presence_hold_ticks;
                        end
                    end
                    PH_RS_FINAL: begin
                        fin = 1'b1; fin_st = ST_PRESENT;
                    end
                    PH_W_LOW: begin
                        if (s.sh[0])
                            s.drv = 1'b0;
                        s.ph  = PH_W_SLOT;
                        s.cnt = 9'(timing.write_slot_ticks);
                    end
                    PH_W_SLOT: begin
                        s.sh     = s.sh >> 1;
                        slot_end = 1'b1;
                    end
                    PH_R_LOW: begin
                        s.drv = 1'b0; s.ph = PH_R_WAIT; s.cnt = 9'(timing.read_sample_ticks);
                    end
                    PH_R_WAIT: begin
                        s.sh  = {level, s.sh[7:1]};
                        s.ph  = PH_R_REC;
                        s.cnt = 9'(timing.read_recovery_ticks);
                    end
                    PH_R_REC: slot_end = 1'b1;
                    PH_GAP:   s = open_slot(s);
                    default: begin
                        s.drv = 1'b0; s.ph = PH_IDLE; s.cnt = '0;
                    end
                endcase
                if (slot_end) begin
                    s.drv = 1'b0;
                    if ((s.op == REQ_WBYTE || s.op == REQ_RBYTE) && s.bidx < 4'(LAST_BIT)) begin
                        s.bidx = s.bidx + 4'd1;
                        s.ph   = PH_GAP;
                        s.cnt  = 9'd1;
                    end else begin
                        if (s.op == REQ_RBYTE)
                            r.rx_byte = s.sh;
                        else if (s.op == REQ_RBIT)
                            r.rx_byte = {7'd0, s.sh[7]};
                        fin = 1'b1;
                    end
                end
                if (fin) begin
                    s.drv = 1'b0; s.ph = PH_IDLE; s.cnt = '0;
                    r.done_res = 1'b1;
                    r.status   = fin_st;
                end
            end
            if (!r.done_res && is_cmd)
                r.status = ST_REJECTED;
        end
        r.bus_drive_low = s.drv;
        r.busy_res      = (s.ph != PH_IDLE);
        return r;
    endfunction

    // Line level seen by the master: random except on the last tick of a phase,
    // where it follows the drive, with a device answering a reset as reset_outcome asks and random data in read slots.
    function automatic logic line_level();
        if (master.ph == PH_IDLE || master.cnt > 9'd1)
            return 1'($urandom_range(0, 1));
        case (master.ph)
            PH_RS_PRE:   return reset_outcome != ST_BUS_LOW;
            PH_RS_LOW1:  return reset_outcome == ST_NO_LOW;
            PH_RS_REL:   return reset_outcome != ST_STUCK;
            PH_RS_PWAIT: return reset_outcome == ST_NO_DEV;
            PH_RS_SHORT: return reset_outcome == ST_SHORT;
            PH_RS_LONG:  return reset_outcome != ST_LONG;
            PH_R_WAIT:   return 1'($urandom_range(0, 1));
            default:     return !master.drv;
        endcase
    endfunction

    function automatic logic [31:0] field_of(input t_cfg c, input t_reg_idx idx);
        case (idx)
            REG_WR1_LOW:  return 32'(c.write_one_low_ticks);
            REG_WR_SLOT:  return 32'(c.write_slot_ticks);
            REG_RD_LOW:   return 32'(c.read_low_ticks);
            REG_RD_SAMP:  return 32'(c.read_sample_ticks);
            REG_RD_REC:   return 32'(c.read_recovery_ticks);
            REG_RST_HALF: return 32'(c.reset_half_ticks);
            REG_PR_WAIT:  return 32'(c.presence_wait_ticks);
            REG_PR_HOLD:  return 32'(c.presence_hold_ticks);
            default:      return '0;
        endcase
    endfunction

    // Stream side

    task automatic send_tick(input t_req req, input logic [7:0] tx, input logic level);
        t_bus_state after;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, level, tx};
        do @(posedge i_clk); while (!s_axis_tready);
        tick_results.push_back(master_tick(master, req, tx, level, after));
        master = after;
    endtask

    // One tick while a command runs; some carry a command, half of the
    // finishing ticks too.
    task automatic busy_tick(input int cmd_pct);
        t_bus_state scratch;
        t_result    peek;
        logic       level;
        t_req       req;
        level = line_level();
        peek  = master_tick(master, REQ_TICK, 8'h00, level, scratch);
        if ((peek.done_res && $urandom_range(0, 1)) || $urandom_range(0, 99) < cmd_pct)
            req = t_req'($urandom_range(REQ_RESET, REQ_SPARE7));
        else
            req = REQ_TICK;
        send_tick(req, 8'($urandom()), level);
    endtask

    task automatic run_cmd(input t_req req, input logic [7:0] tx, input int cmd_pct);
        send_tick(req, tx, line_level());
        while (master.ph != PH_IDLE)
            busy_tick(cmd_pct);
    endtask

    task automatic wait_empty();
        s_axis_tvalid <= 1'b0;
        while (tick_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        while (master.ph != PH_IDLE)
            busy_tick(0);
        wait_empty();
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[14:0]);
            if (tick_results.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                exp = tick_results.pop_front();
                if (got.bus_drive_low !== exp.bus_drive_low) begin
                    $error("bus_drive_low expected %0d got %0d",
                           exp.bus_drive_low, got.bus_drive_low);
                    fail_cnt++;
                end
                if (got.done_res !== exp.done_res) begin
                    $error("done_res expected %0d got %0d", exp.done_res, got.done_res);
                    fail_cnt++;
                end
                if (got.status !== exp.status) begin
                    $error("status expected %0d got %0d", exp.status, got.status);
                    fail_cnt++;
                end
                if (got.rx_byte !== exp.rx_byte) begin
                    $error("rx_byte expected %h got %h", exp.rx_byte, got.rx_byte);
                    fail_cnt++;
                end
                if (got.busy_res !== exp.busy_res) begin
                    $error("busy_res expected %0d got %0d", exp.busy_res, got.busy_res);
                    fail_cnt++;
                end
            end
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Register port

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_WR1_LOW:  timing.write_one_low_ticks = word[3:0];
            REG_WR_SLOT:  timing.write_slot_ticks    = word[6:0];
            REG_RD_LOW:   timing.read_low_ticks      = word[3:0];
            REG_RD_SAMP:  timing.read_sample_ticks   = word[3:0];
            REG_RD_REC:   timing.read_recovery_ticks = word[6:0];
            REG_RST_HALF: timing.reset_half_ticks    = word[8:0];
            REG_PR_WAIT:  timing.presence_wait_ticks = word[6:0];
            REG_PR_HOLD:  timing.presence_hold_ticks = word[8:0];
            default: ;
        endcase
    endtask

    task automatic reg_readback(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== field_of(timing, idx)) begin
            $error("prdata of %s expected %0d got %0d", idx.name(),
                   field_of(timing, idx), prdata);
            fail_cnt++;
        end
    endtask

    // Writes every register, upper word bits optionally junk, then reads all back.
    task automatic load_timing(input t_cfg c, input bit junk);
        logic [31:0] word;
        settle();
        for (int i = 0; i < 8; i++) begin
            word = field_of(c, t_reg_idx'(i));
            if (junk)
                word[31:9] = 23'($urandom());
            reg_write(t_reg_idx'(i), word);
        end
        for (int i = 0; i < 8; i++)
            reg_readback(t_reg_idx'(i));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Tests

    // Register file over its full field widths; slots then run on short timing.
    task automatic test_registers();
        t_cfg        c;
        logic [63:0] raw;
        for (int i = 0; i < 8; i++)
            reg_readback(t_reg_idx'(i));
        psel    <= 1'b0;
        penable <= 1'b0;
        load_timing(TIMING_SLOW, 1'b1);
        load_timing(TIMING_ONES, 1'b0);
        raw = {$urandom(), $urandom()};
        c   = raw[$bits(t_cfg)-1:0];
        load_timing(c, 1'b1);
        load_timing(TIMING_FAST, 1'b0);
        load_timing(TIMING_DEFAULT, 1'b1);
        load_timing(TIMING_SHORT, 1'b1);
    endtask

    task automatic test_reset_outcomes();
        for (t_status st = ST_PRESENT; st <= ST_LONG; st++) begin
            reset_outcome = st;
            run_cmd(REQ_RESET, 8'h00, 0);
        end
        reset_outcome = ST_PRESENT;
    endtask

    task automatic test_slots();
        run_cmd(REQ_WBIT, 8'hFE, 0);
        run_cmd(REQ_WBIT, 8'h01, 0);
        run_cmd(REQ_RBIT, 8'h00, 0);
        run_cmd(REQ_RBIT, 8'hFF, 20);
        run_cmd(REQ_WBYTE, 8'hA5, 10);
        run_cmd(REQ_RBYTE, 8'h5A, 0);
        run_cmd(REQ_SPARE6, 8'hFF, 0);
        run_cmd(REQ_SPARE7, 8'h00, 0);
        run_cmd(REQ_TICK, 8'hFF, 0);
    endtask

    task automatic test_zero_waits();
        load_timing(TIMING_ZERO, 1'b0);
        run_cmd(REQ_RESET, 8'h00, 0);
        run_cmd(REQ_WBYTE, 8'($urandom()), 0);
        run_cmd(REQ_RBIT, 8'h00, 0);
    endtask

    // Receiver holds off while ticks keep coming, then the sender waits for
    // every result before the command is run to its end.
    task automatic test_backpressure();
        load_timing(TIMING_SHORT, 1'b0);
        send_tick(REQ_WBYTE, 8'h3C, line_level());
        sink_hold = 300;
        repeat (20) busy_tick(5);
        wait_empty();
        while (master.ph != PH_IDLE)
            busy_tick(5);
    endtask

    task automatic test_random();
        t_cfg c;
        int   pick;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_gap_pct = 52; sink_stall_pct = 0;  end
                2:       begin src_gap_pct = 0;  sink_stall_pct = 52; end
                default: begin src_gap_pct = 15; sink_stall_pct = 15; end
            endcase
            c.write_one_low_ticks = 4'($urandom_range(0, 3));
            c.write_slot_ticks    = 7'($urandom_range(0, 4));
            c.read_low_ticks      = 4'($urandom_range(0, 3));
            c.read_sample_ticks   = 4'($urandom_range(0, 3));
            c.read_recovery_ticks = 7'($urandom_range(0, 4));
            c.reset_half_ticks    = 9'($urandom_range(0, 4));
            c.presence_wait_ticks = 7'($urandom_range(0, 3));
            c.presence_hold_ticks = 9'($urandom_range(0, 4));
            load_timing(c, 1'($urandom_range(0, 1)));
            repeat (5) begin
                pick = $urandom_range(0, 9);
                reset_outcome = $urandom_range(0, 1) ? ST_PRESENT
                                                      : t_status'($urandom_range(ST_PRESENT, ST_LONG));
                case (pick) inside
                    0, 1: run_cmd(REQ_WBIT, 8'($urandom()), 8);
                    2, 3: run_cmd(REQ_RBIT, 8'($urandom()), 8);
                    4:    run_cmd(REQ_WBYTE, 8'($urandom()), 3);
                    5:    run_cmd(REQ_RBYTE, 8'($urandom()), 3);
                    6:    run_cmd(REQ_RESET, 8'($urandom()), 1);
                    default: begin
                        repeat ($urandom_range(1, 4)) begin
                            case ($urandom_range(0, 2))
                                0:       send_tick(REQ_TICK, 8'($urandom()), line_level());
                                1:       send_tick(REQ_SPARE6, 8'($urandom()), line_level());
                                default: send_tick(REQ_SPARE7, 8'($urandom()), line_level());
                            endcase
                        end
                    end
                endcase
            end
        end
        src_gap_pct    = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        test_reset_outcomes();
        test_slots();
        test_zero_waits();
        test_backpressure();
        test_random();
        wait_empty();
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
